// File: design/spq_pkg.sv
// Package for the sorted priority queue: sizes, codes, control struct, helpers.
// Used by the channel interfaces, the cell, the top level and the checker.
// Depends on nothing else.
package spq_pkg;

  // Queue geometry.
  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W      = $clog2(DEPTH);

  // Field widths on the channels and the register port.
  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned ERR_W    = 2;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  // Operation codes carried by the input channel.
  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2
  } spq_op_e;

  // Error codes reported with every result.
  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } spq_err_e;

  // Register byte addresses.
  localparam logic [PADDR_W-1:0] REG_DESCENDING = 3'd0;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                  ins;   // insert that will succeed
    logic                  rem;   // remove that will succeed
    logic                  desc;  // largest value at the head
    logic [DATA_WIDTH-1:0] data;  // value being inserted
  } spq_ctrl_t;

  // Takes the low DATA_WIDTH bits of an input field.
  function automatic logic [DATA_WIDTH-1:0] to_data(input logic [FIELD_W-1:0] f);
    logic [63:0] wide;
    wide = 64'(f);
    return wide[DATA_WIDTH-1:0];
  endfunction

  // Sign-extends a stored value and cuts it to an output field.
  function automatic logic [FIELD_W-1:0] to_field(input logic [DATA_WIDTH-1:0] d);
    logic signed [63:0] wide;
    wide = 64'($signed(d));
    return wide[FIELD_W-1:0];
  endfunction

endpackage

// File: design/spq_in_if.sv
// Input channel of the sorted priority queue: valid/ready plus one operation.
// Depends on spq_pkg.
interface spq_in_if
  import spq_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [FIELD_W-1:0]  value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

// File: design/spq_out_if.sv
// Result channel of the sorted priority queue: valid/ready plus status fields.
// Depends on spq_pkg.
interface spq_out_if
  import spq_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] removed_value;
  logic               removed_valid;
  logic [FIELD_W-1:0] head_value;
  logic [FIELD_W-1:0] tail_value;
  logic [COUNT_W-1:0] entry_count;
  logic               queue_empty;
  logic               is_full;
  logic [ERR_W-1:0]   error_code;

  modport source (output valid, output removed_value, output removed_valid,
                  output head_value, output tail_value, output entry_count,
                  output queue_empty, output is_full, output error_code, input ready);
  modport sink   (input valid, input removed_value, input removed_valid,
                  input head_value, input tail_value, input entry_count,
                  input queue_empty, input is_full, input error_code, output ready);
endinterface

// File: design/spq_cell.sv
// One cell of the sorted chain: holds one entry and trades it with its neighbors.
// Depends on spq_pkg.
module spq_cell
  import spq_pkg::*;
(
  input  logic                  clk_i,
  input  spq_ctrl_t             ctrl_i,
  input  logic                  occupied_i,   // this cell holds a live entry
  input  logic                  at_tail_i,    // this cell is the first free slot
  input  logic                  found_i,      // insert point lies nearer the head
  input  logic [DATA_WIDTH-1:0] left_data_i,  // entry of the cell nearer the head
  input  logic [DATA_WIDTH-1:0] right_data_i, // entry of the cell nearer the tail
  output logic                  found_o,
  output logic [DATA_WIDTH-1:0] data_o
);

  logic [DATA_WIDTH-1:0] entry_q, entry_d;
  logic                  new_first;
  logic                  hit;

  // The new value goes strictly before this entry in the current order.
  assign new_first = ctrl_i.desc ? ($signed(ctrl_i.data) > $signed(entry_q))
                                 : ($signed(ctrl_i.data) < $signed(entry_q));
  assign hit     = occupied_i & new_first;
  assign found_o = found_i | hit;
  assign data_o  = entry_q;

  // Insert: cells past the insert point take their left neighbor, the insert
  // point takes the new value. Remove: every cell takes its right neighbor.
  always_comb begin
    entry_d = entry_q;
    priority if (ctrl_i.ins) begin
      if (found_i) begin
        entry_d = left_data_i;
      end else if (hit || at_tail_i) begin
        entry_d = ctrl_i.data;
      end
    end else if (ctrl_i.rem) begin
      entry_d = right_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// File: design/sorted_priority_queue_top.sv
// Sorted priority queue built as a chain of DEPTH cells. Every operation (insert,
// remove head, clear) is applied to the whole chain at once: all cells compare the new value in
// parallel, the insert point ripples down a found chain, and every cell loads
// its own, its left or its right neighbor's entry at the same clock edge. The
// result appears in an output register in the cycle after the transfer, and a new
// operation is taken in every cycle in which that register is empty or being
// emptied, so the sustained rate is one item per cycle. Entries are ordered
// ascending unless descending_order (APB address 0, bit 0) is set; change it
// only while the queue is idle. Depends on spq_pkg, spq_in_if, spq_out_if and
// spq_cell.
module sorted_priority_queue_top
  import spq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  spq_in_if.sink             in_i,
  spq_out_if.source          out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic                  desc_q;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  out_valid_q;
  logic [FIELD_W-1:0]    removed_q, removed_d;
  logic                  rvalid_q, rvalid_d;
  spq_err_e              err_q, err_d;

  logic                  take;
  logic                  empty, full;
  spq_op_e               op;
  spq_ctrl_t             ctrl;
  logic [DEPTH:0]        found;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [IDX_W-1:0]      tail_idx;

  // Register port: one mode bit, no wait states.
  assign pready = 1'b1;
  assign prdata = (paddr == REG_DESCENDING) ? PDATA_W'(desc_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr == REG_DESCENDING) begin
      desc_q <= pwdata[0];
    end
  end

  // Handshake: the state only moves when the result register can take a result.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign take       = in_i.valid && in_i.ready;
  assign op         = spq_op_e'(in_i.opcode);
  assign empty      = (count_q == '0);
  assign full       = (count_q == CNT_W'(DEPTH));

  // Decode the operation into the cell command, the count and the report.
  always_comb begin
    ctrl.ins  = 1'b0;
    ctrl.rem  = 1'b0;
    ctrl.desc = desc_q;
    ctrl.data = to_data(in_i.value);
    count_d   = count_q;
    removed_d = '0;
    rvalid_d  = 1'b0;
    err_d     = ERR_OK;
    if (take) begin
      unique case (op)
        OP_INSERT: begin
          if (full) begin
            err_d = ERR_FULL;
          end else begin
            ctrl.ins = 1'b1;
            count_d  = count_q + 1'b1;
          end
        end
        OP_REMOVE: begin
          if (empty) begin
            err_d = ERR_EMPTY;
          end else begin
            ctrl.rem  = 1'b1;
            count_d   = count_q - 1'b1;
            removed_d = to_field(cell_data[0]);
            rvalid_d  = 1'b1;
          end
        end
        OP_CLEAR: begin
          count_d = '0;
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
  end

  // The chain of cells.
  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data, right_data;

    if (i == 0) begin : g_head
      assign left_data = ctrl.data;
    end else begin : g_mid
      assign left_data = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_body
      assign right_data = cell_data[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occupied_i   (CNT_W'(i) < count_q),
      .at_tail_i    (CNT_W'(i) == count_q),
      .found_i      (found[i]),
      .left_data_i  (left_data),
      .right_data_i (right_data),
      .found_o      (found[i+1]),
      .data_o       (cell_data[i])
    );
  end

  // Count and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      removed_q <= removed_d;
      rvalid_q  <= rvalid_d;
      err_q     <= err_d;
    end
  end

  // Status fields are read from the state, which holds while a result waits.
  assign tail_idx            = IDX_W'(count_q - 1'b1);
  assign out_o.valid         = out_valid_q;
  assign out_o.removed_value = removed_q;
  assign out_o.removed_valid = rvalid_q;
  assign out_o.head_value    = empty ? '0 : to_field(cell_data[0]);
  assign out_o.tail_value    = empty ? '0 : to_field(cell_data[tail_idx]);
  assign out_o.entry_count   = COUNT_W'(count_q);
  assign out_o.queue_empty   = empty;
  assign out_o.is_full       = full;
  assign out_o.error_code    = err_q;

endmodule

// File: design/spq_checker.sv
// Port-level checker for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_top.
module spq_checker
  import spq_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [FIELD_W-1:0] removed_value_i,
  input logic               removed_valid_i,
  input logic [COUNT_W-1:0] entry_count_i,
  input logic               queue_empty_i,
  input logic               is_full_i,
  input logic [ERR_W-1:0]   error_code_i
);

  // A stalled result keeps its status.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(entry_count_i) && $stable(error_code_i))
    else $error("result changed while stalled");

  // The empty flag agrees with the count.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (queue_empty_i == (entry_count_i == '0)))
    else $error("empty flag disagrees with count");

  // A popped entry comes only with a clean status.
  a_pop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && removed_valid_i |-> error_code_i == ERR_OK && !is_full_i)
    else $error("popped entry with error or full queue");

  // A refused insert leaves the queue full.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && error_code_i == ERR_FULL |-> is_full_i && !removed_valid_i)
    else $error("full error without full queue");

  // No popped value without a pop.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !removed_valid_i |-> removed_value_i == '0)
    else $error("removed value without a pop");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .removed_value_i (out_o.removed_value),
  .removed_valid_i (out_o.removed_valid),
  .entry_count_i   (out_o.entry_count),
  .queue_empty_i   (out_o.queue_empty),
  .is_full_i       (out_o.is_full),
  .error_code_i    (out_o.error_code)
);
